// ===== rtl/core/dsfr_pkg.sv =====
`default_nettype none

package dsfr_pkg;

  localparam int MAX_FRAME_DEF = 40;
  // widest store address over the supported depth range (up to 64 entries)
  localparam int MEM_AW_MAX    = 6;

  localparam logic [7:0] SHORT_SYNC_RST = 8'hF1;
  localparam logic [7:0] LONG_SYNC_RST  = 8'hF2;
  localparam logic [5:0] SHORT_LEN_RST  = 6'd7;
  localparam logic [5:0] LONG_LEN_RST   = 6'd33;

  localparam logic [1:0] REG_SHORT_SYNC = 2'd0;
  localparam logic [1:0] REG_LONG_SYNC  = 2'd1;
  localparam logic [1:0] REG_SHORT_LEN  = 2'd2;
  localparam logic [1:0] REG_LONG_LEN   = 2'd3;

  typedef struct packed {
    logic [7:0] short_sync;
    logic [7:0] long_sync;
    logic [5:0] short_len;
    logic [5:0] long_len;
  } cfg_t;

  typedef struct packed {
    logic                  we;
    logic [MEM_AW_MAX-1:0] waddr;
    logic [7:0]            wdata;
    logic                  re;
    logic [MEM_AW_MAX-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsfr_store.sv =====
`default_nettype none

module dsfr_store
  import dsfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [7:0]    rd_data
);

  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  logic [7:0] mem [MAX_FRAME];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/dsfr_ctrl.sv =====
`default_nettype none

module dsfr_ctrl
  import dsfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_byte_index,
  output logic            out_frame_kind,
  output logic            out_last_byte,
  output mem_req_t        mem_req
);

  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int LW = (CW > 6) ? CW : 6;

  localparam logic [1:0] S_HUNT = 2'd0;
  localparam logic [1:0] S_RECV = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_SHOW = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          kind_r, kind_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;

  logic          in_acc;
  logic [7:0]    confirm_code;
  logic [5:0]    len_raw;
  logic [LW-1:0] len_sel, eff_len;
  logic [LW:0]   cnt_inc, rd_inc;
  logic          last;

  assign in_acc       = in_valid && in_ready;
  assign confirm_code = kind_r ? cfg.long_sync : cfg.short_sync;
  assign len_raw      = kind_r ? cfg.long_len : cfg.short_len;
  assign len_sel      = LW'(len_raw);

  // clamp length to [2, MAX_FRAME]
  always_comb begin
    if (len_sel < LW'(2)) begin
      eff_len = LW'(2);
    end else if (len_sel > LW'(MAX_FRAME)) begin
      eff_len = LW'(MAX_FRAME);
    end else begin
      eff_len = len_sel;
    end
  end

  assign cnt_inc = (LW + 1)'(cnt_r) + (LW + 1)'(1);
  assign rd_inc  = (LW + 1)'(rd_idx_r) + (LW + 1)'(1);
  assign last    = (rd_inc == (LW + 1)'(len_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    mem_req       = '0;
    mem_req.wdata = in_rx_byte;
    mem_req.raddr = MEM_AW_MAX'(rd_idx_r);
    unique case (state_r)
      S_HUNT: begin
        if (in_acc) begin
          if (in_rx_byte == cfg.short_sync || in_rx_byte == cfg.long_sync) begin
            // equal codes resolve to a short frame
            kind_nxt      = (in_rx_byte != cfg.short_sync);
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            cnt_nxt       = CW'(1);
            state_nxt     = S_RECV;
          end
        end
      end
      S_RECV: begin
        if (in_acc) begin
          if (cnt_r == CW'(1) && in_rx_byte != confirm_code) begin
            // bad confirm: drop frame, byte not re-checked
            cnt_nxt   = '0;
            state_nxt = S_HUNT;
          end else begin
            mem_req.we    = (cnt_r < CW'(MAX_FRAME));
            mem_req.waddr = MEM_AW_MAX'(cnt_r[AW-1:0]);
            if (cnt_inc < (LW + 1)'(eff_len)) begin
              cnt_nxt = cnt_inc[CW-1:0];
            end else begin
              cnt_nxt    = '0;
              len_nxt    = eff_len;
              rd_idx_nxt = '0;
              state_nxt  = S_READ;
            end
          end
        end
      end
      S_READ: begin
        mem_req.re = 1'b1;
        state_nxt  = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (last) begin
            state_nxt = S_HUNT;
          end else begin
            rd_idx_nxt = rd_inc[AW-1:0];
            state_nxt  = S_READ;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_HUNT;
      cnt_r    <= '0;
      kind_r   <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      kind_r   <= kind_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  assign in_ready       = (state_r == S_HUNT) || (state_r == S_RECV);
  assign out_valid      = (state_r == S_SHOW);
  assign out_byte_index = 6'(rd_idx_r);
  assign out_frame_kind = kind_r;
  assign out_last_byte  = last;

endmodule

`default_nettype wire

// ===== rtl/core/dual_sync_frame_receiver_core.sv =====
`default_nettype none
// Sequence: a completed frame goes to S_READ (store read), then S_SHOW (first beat).
// Throughput: one rx beat per cycle while a frame is being gathered; the drain
//   takes a store read, then an output hold, per result beat, and S_SHOW waits
//   for out_ready; the input is stalled until the whole frame has drained.
// Reset: synchronous active-low rst_n; config regs return to defaults, FSM hunts.
//   The frame store is not cleared; entries are always written before read.

module dual_sync_frame_receiver_core
  import dsfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // config write port
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // rx byte beats
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  // frame byte beats
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic [5:0]      out_byte_index,
  output logic            out_frame_kind,
  output logic            out_last_byte
);

  cfg_t     cfg_r, cfg_nxt;
  mem_req_t mem_req;

  // config register file; only indices 0..3 exist
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_SYNC: cfg_nxt.short_sync = cfg_wdata;
        REG_LONG_SYNC:  cfg_nxt.long_sync  = cfg_wdata;
        REG_SHORT_LEN:  cfg_nxt.short_len  = cfg_wdata[5:0];
        REG_LONG_LEN:   cfg_nxt.long_len   = cfg_wdata[5:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_sync <= SHORT_SYNC_RST;
      cfg_r.long_sync  <= LONG_SYNC_RST;
      cfg_r.short_len  <= SHORT_LEN_RST;
      cfg_r.long_len   <= LONG_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: hunts sync, gathers bytes, then drains the store
  dsfr_ctrl #(
    .MAX_FRAME (MAX_FRAME)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_index (out_byte_index),
    .out_frame_kind (out_frame_kind),
    .out_last_byte  (out_last_byte),
    .mem_req        (mem_req)
  );

  // frame store; read data is registered and held through the output beat
  dsfr_store #(
    .MAX_FRAME (MAX_FRAME)
  ) u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (out_frame_byte)
  );

endmodule

`default_nettype wire
